// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL of the non-maximum suppression block.
// Expects a clock i_clk and an active-low synchronous reset i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define GNMS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define GNMS_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// File: rtl/gnms_pkg.sv
// Package for the gradient non-maximum suppression block.
// Register indexes, reset values and the direction code; no dependencies.
package gnms_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_ENABLE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_LOW     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_HIGH    = 3'd4;

    localparam logic [5:0] RST_FRAME_WIDTH  = 6'd32;
    localparam logic [9:0] RST_FRAME_HEIGHT = 10'd32;
    localparam logic [7:0] RST_BAND_LOW     = 8'd0;
    localparam logic [7:0] RST_BAND_HIGH    = 8'd255;

    localparam logic [5:0] MIN_FRAME_WIDTH  = 6'd3;
    localparam logic [9:0] MIN_FRAME_HEIGHT = 10'd3;

    // Gradient direction: which pair of neighbors is compared.
    typedef enum logic [1:0] {
        DIR_HORIZONTAL = 2'd0,   // left / right
        DIR_ANTI_DIAG  = 2'd1,   // up-right / down-left
        DIR_VERTICAL   = 2'd2,   // up / down
        DIR_MAIN_DIAG  = 2'd3    // up-left / down-right
    } t_dir;

endpackage

// File: rtl/gnms_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module gnms_ram #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [DATA_W-1:0]        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [DATA_W-1:0]        o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= mem[i_raddr];
        end
    end

endmodule

// File: rtl/gradient_non_maximum_suppression_unit.sv
// Gradient non-maximum suppression, top level.
// Uses gnms_pkg, gnms_ram and assert_macros.svh.
//
// Raster-order pixels (magnitude + 2-bit direction) go in; each pixel's
// magnitude comes out if it is no smaller than both neighbors along its
// direction (neighbors outside the frame do not count), else zero, then
// optionally zeroed outside [band_low, band_high]. Results lag the input by
// one row and one pixel; the last row is flushed by the frame's final pixel,
// whose result beat carries end_of_frame. The block accepts one pixel per
// cycle while each pixel yields at most one result and the output is not
// stalled. A row's last pixel yields two results; the extra beat leaves while
// the next row's first pixel, which yields none, passes through, so the input
// does not wait there. In the last row every pixel but the first yields two
// results (four at its last column), so there the input waits on the single
// result port, which moves at most one beat per cycle; the four-beat flush
// drains while the next frame's first row, which yields nothing, streams in.
// Both line buffers and the direction line sit in one RAM entry per column,
// read when a pixel is taken and written back (row shifted down, new pixel
// in) when that pixel moves on from stage B to the compare stage;
// consecutive pixels always touch different columns, so no forwarding is
// needed. There is no clearing pass: out-of-frame neighbors are masked, so
// stale RAM contents never reach a result. Pipeline: take/read -> window
// shift/write-back -> compare -> result queue (up to four beats) -> output.
`include "assert_macros.svh"

module gradient_non_maximum_suppression_unit #(
    parameter int MAX_WIDTH  = 32,
    parameter int PIXEL_BITS = 8
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // configuration
    input  logic                             i_cfg_wr_en,
    input  logic [gnms_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [gnms_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    // pixel input
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [7:0]                       i_magnitude,
    input  logic [1:0]                       i_direction,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [7:0]                       o_kept_value,
    output logic                             o_end_of_frame
);

    import gnms_pkg::*;

    localparam int AW = $clog2(MAX_WIDTH);          // column address
    localparam int WW = $clog2(MAX_WIDTH + 1);      // holds the width itself
    localparam int PB = PIXEL_BITS;
    localparam int CW = (PB > 8) ? PB : 8;          // band compare width
    localparam int DW = 2 * PB + 2;                 // {older, newer, dir}
    localparam logic [5:0] MAXW6 = 6'(MAX_WIDTH);

    // ---------------- configuration registers ----------------
    logic [5:0] r_frame_width;
    logic [9:0] r_frame_height;
    logic       r_band_en;
    logic [7:0] r_band_low;
    logic [7:0] r_band_high;
    logic       cfg_restart;

    assign cfg_restart = i_cfg_wr_en &&
                         (i_cfg_index == REG_FRAME_WIDTH || i_cfg_index == REG_FRAME_HEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_band_en      <= 1'b0;
            r_band_low     <= RST_BAND_LOW;
            r_band_high    <= RST_BAND_HIGH;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                REG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[5:0];
                REG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[9:0];
                REG_BAND_ENABLE:  r_band_en      <= i_cfg_data[0];
                REG_BAND_LOW:     r_band_low     <= i_cfg_data[7:0];
                REG_BAND_HIGH:    r_band_high    <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // effective frame size, clamped
    logic [5:0]    w_eff6;
    logic [WW-1:0] w_eff;
    logic [WW-1:0] w_last;
    logic [9:0]    h_eff;
    logic [9:0]    h_last;

    always_comb begin
        priority if (r_frame_width < MIN_FRAME_WIDTH) begin
            w_eff6 = MIN_FRAME_WIDTH;
        end else if (r_frame_width > MAXW6) begin
            w_eff6 = MAXW6;
        end else begin
            w_eff6 = r_frame_width;
        end
        w_eff  = WW'(w_eff6);
        w_last = w_eff - WW'(1);
        h_eff  = (r_frame_height < MIN_FRAME_HEIGHT) ? MIN_FRAME_HEIGHT : r_frame_height;
        h_last = h_eff - 10'd1;
    end

    // ---------------- stage A: take pixel, read line RAM ----------------
    logic [AW-1:0] r_col, n_col;
    logic [9:0]    r_row, n_row;
    logic [AW-1:0] c_cur;
    logic [9:0]    r_cur;
    logic          last_col, last_row;
    logic          in_fire;
    logic          c_adv;          // compare stage moves on (also frees B)

    assign c_cur    = (WW'(r_col) >= w_eff) ? '0 : r_col;
    assign r_cur    = (r_row >= h_eff) ? 10'd0 : r_row;
    assign last_col = (WW'(c_cur) == w_last);
    assign last_row = (r_cur == h_last);

    logic r_b_valid;
    assign o_in_ready = !r_b_valid || c_adv;
    assign in_fire    = i_in_valid && o_in_ready;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        priority if (cfg_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (in_fire) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? 10'd0 : r_cur + 10'd1;
            end else begin
                n_col = c_cur + AW'(1);
                n_row = r_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // B stage payload
    logic [PB-1:0] r_b_mag;
    logic [1:0]    r_b_dir;
    logic [AW-1:0] r_b_col;
    logic          r_b_emit;       // row >= 1 and col >= 1
    logic          r_b_flush;      // row >= 1 and last column
    logic          r_b_last_row;
    logic          r_b_lv;         // col > 1: left neighbor of col-1 exists
    logic          r_b_uv;         // row > 1: upper neighbor exists

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (in_fire) begin
            r_b_valid <= 1'b1;
        end else if (c_adv) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_b_mag      <= PB'(i_magnitude);
            r_b_dir      <= i_direction;
            r_b_col      <= c_cur;
            r_b_emit     <= (r_cur != 10'd0) && (c_cur != '0);
            r_b_flush    <= (r_cur != 10'd0) && last_col;
            r_b_last_row <= last_row;
            r_b_lv       <= (c_cur > AW'(1));
            r_b_uv       <= (r_cur > 10'd1);
        end
    end

    // ---------------- line RAM: {row r-2, row r-1, direction of row r-1} ----
    logic          ram_we;
    logic [DW-1:0] ram_rdata;
    logic [PB-1:0] rd_older, rd_newer;
    logic [1:0]    rd_dir;

    assign {rd_older, rd_newer, rd_dir} = ram_rdata;
    assign ram_we = r_b_valid && c_adv;

    gnms_ram #(
        .DATA_W (DW),
        .DEPTH  (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_b_col),
        .i_wdata ({rd_newer, r_b_mag, r_b_dir}),
        .i_re    (in_fire),
        .i_raddr (c_cur),
        .o_rdata (ram_rdata)
    );

    // ---------------- stage B: window shift ----------------
    // Three columns, index 2 newest. Rows: top = r-2, mid = r-1, bot = r.
    logic [PB-1:0] r_wt [3];
    logic [PB-1:0] r_wm [3];
    logic [PB-1:0] r_wb [3];
    logic [1:0]    r_du1, r_du2;   // directions of row r-1, columns 1 and 2
    logic [1:0]    r_dh1, r_dh2;   // directions of row r

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_wt[0] <= r_wt[1];  r_wt[1] <= r_wt[2];  r_wt[2] <= rd_older;
            r_wm[0] <= r_wm[1];  r_wm[1] <= r_wm[2];  r_wm[2] <= rd_newer;
            r_wb[0] <= r_wb[1];  r_wb[1] <= r_wb[2];  r_wb[2] <= r_b_mag;
            r_du1   <= r_du2;    r_du2   <= rd_dir;
            r_dh1   <= r_dh2;    r_dh2   <= r_b_dir;
        end
    end

    logic r_c_valid;
    logic r_c_emit, r_c_flush, r_c_last_row, r_c_lv, r_c_uv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_valid <= 1'b0;
        end else if (c_adv) begin
            r_c_valid <= r_b_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ram_we) begin
            r_c_emit     <= r_b_emit;
            r_c_flush    <= r_b_flush;
            r_c_last_row <= r_b_last_row;
            r_c_lv       <= r_b_lv;
            r_c_uv       <= r_b_uv;
        end
    end

    // ---------------- stage C: compare ----------------
    function automatic logic [PB-1:0] judge(
        input logic [PB-1:0] v,
        input logic [PB-1:0] lf, rt, up, dn, ul, ur, dl, dr,
        input logic [1:0]    dir,
        input logic          lv, rv, uv, dv
    );
        logic keep;
        keep = 1'b1;
        unique case (t_dir'(dir))
            DIR_HORIZONTAL: begin
                if (lv && lf > v) keep = 1'b0;
                if (rv && rt > v) keep = 1'b0;
            end
            DIR_ANTI_DIAG: begin
                if (uv && rv && ur > v) keep = 1'b0;
                if (dv && lv && dl > v) keep = 1'b0;
            end
            DIR_VERTICAL: begin
                if (uv && up > v) keep = 1'b0;
                if (dv && dn > v) keep = 1'b0;
            end
            DIR_MAIN_DIAG: begin
                if (uv && lv && ul > v) keep = 1'b0;
                if (dv && rv && dr > v) keep = 1'b0;
            end
        endcase
        return keep ? v : '0;
    endfunction

    function automatic logic [7:0] band_gate(
        input logic [PB-1:0] v,
        input logic          en,
        input logic [7:0]    lo,
        input logic [7:0]    hi
    );
        logic outside;
        outside = (CW'(v) < CW'(lo)) || (CW'(v) > CW'(hi));
        return (en && outside) ? 8'd0 : 8'(v);
    endfunction

    // N*: centre at column 1 (pixel col-1); F*: centre at column 2 (last pixel).
    // *1: centre in row r-1; *2: centre in row r (last row only).
    logic [7:0] val_n1, val_n2, val_f1, val_f2;

    assign val_n1 = band_gate(judge(r_wm[1], r_wm[0], r_wm[2], r_wt[1], r_wb[1],
                                    r_wt[0], r_wt[2], r_wb[0], r_wb[2], r_du1,
                                    r_c_lv, 1'b1, r_c_uv, 1'b1),
                              r_band_en, r_band_low, r_band_high);
    assign val_n2 = band_gate(judge(r_wb[1], r_wb[0], r_wb[2], r_wm[1], r_wb[1],
                                    r_wm[0], r_wm[2], r_wb[0], r_wb[2], r_dh1,
                                    r_c_lv, 1'b1, 1'b1, 1'b0),
                              r_band_en, r_band_low, r_band_high);
    assign val_f1 = band_gate(judge(r_wm[2], r_wm[1], r_wm[2], r_wt[2], r_wb[2],
                                    r_wt[1], r_wt[2], r_wb[1], r_wb[2], r_du2,
                                    1'b1, 1'b0, r_c_uv, 1'b1),
                              r_band_en, r_band_low, r_band_high);
    assign val_f2 = band_gate(judge(r_wb[2], r_wb[1], r_wb[2], r_wm[2], r_wb[2],
                                    r_wm[1], r_wm[2], r_wb[1], r_wb[2], r_dh2,
                                    1'b1, 1'b0, 1'b1, 1'b0),
                              r_band_en, r_band_low, r_band_high);

    // result group in output order
    logic [7:0] grp_val [4];
    logic       grp_eof;           // last entry of a four-beat group ends the frame
    logic [2:0] grp_num;

    always_comb begin
        grp_eof = r_c_last_row;
        if (r_c_last_row) begin
            grp_val[0] = val_n1;
            grp_val[1] = val_n2;
            grp_val[2] = val_f1;
            grp_val[3] = val_f2;
            grp_num    = r_c_flush ? 3'd4 : 3'd2;
        end else begin
            grp_val[0] = val_n1;
            grp_val[1] = val_f1;
            grp_val[2] = val_f1;
            grp_val[3] = val_f2;
            grp_num    = r_c_flush ? 3'd2 : 3'd1;
        end
        if (!r_c_valid || !r_c_emit) begin
            grp_num = 3'd0;
        end
    end

    // ---------------- result queue / output register ----------------
    logic [7:0] r_q   [4];
    logic [3:0] r_qe;
    logic [2:0] r_cnt;
    logic       out_fire;
    logic       q_load;

    assign o_out_valid    = (r_cnt != 3'd0);
    assign o_kept_value   = r_q[0];
    assign o_end_of_frame = r_qe[0];
    assign out_fire       = o_out_valid && i_out_ready;

    // queue can take a new group once its last beat leaves
    assign c_adv  = (grp_num == 3'd0) || (r_cnt == 3'd0) ||
                    (r_cnt == 3'd1 && out_fire);
    assign q_load = c_adv && (grp_num != 3'd0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (q_load) begin
            r_cnt <= grp_num;
        end else if (out_fire) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qe <= '0;
        end else if (q_load) begin
            r_qe <= {grp_eof, 3'b000};
        end else if (out_fire) begin
            r_qe <= {1'b0, r_qe[3:1]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_load) begin
            r_q[0] <= grp_val[0];
            r_q[1] <= grp_val[1];
            r_q[2] <= grp_val[2];
            r_q[3] <= grp_val[3];
        end else if (out_fire) begin
            r_q[0] <= r_q[1];
            r_q[1] <= r_q[2];
            r_q[2] <= r_q[3];
        end
    end

    // ---------------- assertions ----------------
    `GNMS_ASSERT_ALWAYS(a_reset_clears, (!i_rst_n) |=> (!o_out_valid && !r_b_valid && !r_c_valid), "pipeline not empty after reset")
    `GNMS_ASSERT(a_eof_last_beat, (o_out_valid && o_end_of_frame) |-> (r_cnt == 3'd1), "end_of_frame beat not last of its group")
    `GNMS_ASSERT(a_group_load, q_load |=> (r_cnt == $past(grp_num)), "result group loaded with wrong beat count")

endmodule
